/* src/vgacc_pkg.sv */
// ----------------------------------------------------------------------------
// vgacc_pkg
// shared constants, types and helper functions of the voxel gaussian accumulator
// ----------------------------------------------------------------------------
package vgacc_pkg;

	localparam int TABLE_DEPTH = 4096;
	localparam int COORD_BITS  = 24;
	localparam int MAX_PROBES  = 8;
	localparam int COUNT_BITS  = 20;

	localparam int SLOT_W     = $clog2(TABLE_DEPTH);
	localparam int PROBE_W    = $clog2(MAX_PROBES + 1);
	localparam int VS_W       = 23;
	localparam int OUT_SLOT_W = 12;
	localparam int STATUS_W   = 3;
	localparam int SCAT_W     = 64;
	localparam int ENERGY_W   = 63;
	localparam int KEY_W      = 3 * COORD_BITS + 1;
	localparam int MEAN_W     = COORD_BITS + 8;
	localparam int DIFF_W     = MEAN_W + 1;
	localparam int DIVIDEND_W = DIFF_W;
	localparam int DIVISOR_W  = (COUNT_BITS + 1 > VS_W) ? COUNT_BITS + 1 : VS_W;
	localparam int QUOT_W     = DIVIDEND_W + 1;
	localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);
	localparam int MAG_W      = DIFF_W;
	localparam int HALF_W     = (MAG_W + 1) / 2;
	localparam int PROD_W     = 2 * MAG_W;
	localparam int PEXT_W     = (PROD_W > 72) ? PROD_W : 72;

	localparam logic [VS_W-1:0]       VS_RESET  = VS_W'(512);
	localparam logic [COUNT_BITS-1:0] CNT_MAX   = '1;
	localparam logic [PROBE_W-1:0]    PROBE_LAST = PROBE_W'(MAX_PROBES - 1);
	localparam logic signed [SCAT_W-1:0] SCAT_MAX = {1'b0, {(SCAT_W-1){1'b1}}};
	localparam logic signed [SCAT_W-1:0] SCAT_MIN = {1'b1, {(SCAT_W-1){1'b0}}};

	localparam logic [31:0] HASH_KX = 32'd73856093;
	localparam logic [31:0] HASH_KY = 32'd19349663;
	localparam logic [31:0] HASH_KZ = 32'd83492791;

	typedef enum logic [STATUS_W-1:0] {
		ST_ADDED   = 3'd0,
		ST_NEW     = 3'd1,
		ST_FULL    = 3'd2,
		ST_SAT     = 3'd3,
		ST_CLEARED = 3'd4
	} status_t;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] num;
		logic [DIVISOR_W-1:0]  den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [QUOT_W-1:0] quot;
	} div_rsp_t;

	typedef struct packed {
		logic             start;
		logic [MAG_W-1:0] a;
		logic [MAG_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] prod;
	} mul_rsp_t;

	// only the low slot bits of each product reach the table index
	function automatic logic [SLOT_W-1:0] hash_slot(
		input logic [COORD_BITS-1:0] cx,
		input logic [COORD_BITS-1:0] cy,
		input logic [COORD_BITS-1:0] cz
	);
		logic [31:0]       xe, ye, ze;
		logic [SLOT_W-1:0] hx, hy, hz;
		xe = {{(32-COORD_BITS){1'b0}}, cx};
		ye = {{(32-COORD_BITS){1'b0}}, cy};
		ze = {{(32-COORD_BITS){1'b0}}, cz};
		hx = xe[SLOT_W-1:0] * HASH_KX[SLOT_W-1:0];
		hy = ye[SLOT_W-1:0] * HASH_KY[SLOT_W-1:0];
		hz = ze[SLOT_W-1:0] * HASH_KZ[SLOT_W-1:0];
		return hx ^ hy ^ hz;
	endfunction

	function automatic logic signed [SCAT_W-1:0] sat_add(
		input logic signed [SCAT_W-1:0] a,
		input logic signed [SCAT_W-1:0] b
	);
		logic signed [SCAT_W:0] s;
		s = {a[SCAT_W-1], a} + {b[SCAT_W-1], b};
		if (s[SCAT_W] != s[SCAT_W-1]) begin
			return s[SCAT_W] ? SCAT_MIN : SCAT_MAX;
		end
		return s[SCAT_W-1:0];
	endfunction

	function automatic logic [ENERGY_W-1:0] pos_part(input logic signed [SCAT_W-1:0] v);
		return v[SCAT_W-1] ? '0 : v[ENERGY_W-1:0];
	endfunction

	function automatic logic [ENERGY_W-1:0] energy_add(
		input logic [ENERGY_W-1:0] a,
		input logic [ENERGY_W-1:0] b
	);
		logic [ENERGY_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[ENERGY_W] ? '1 : s[ENERGY_W-1:0];
	endfunction

endpackage

/* src/vgacc_req_if.sv */
// ----------------------------------------------------------------------------
// vgacc_req_if
// request channel: clear or add one point
// ----------------------------------------------------------------------------
interface vgacc_req_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  req_type;
	logic signed [vgacc_pkg::COORD_BITS-1:0] point_x;
	logic signed [vgacc_pkg::COORD_BITS-1:0] point_y;
	logic signed [vgacc_pkg::COORD_BITS-1:0] point_z;

	modport source (output valid, req_type, point_x, point_y, point_z, input ready);
	modport sink (input valid, req_type, point_x, point_y, point_z, output ready);
endinterface

/* src/vgacc_rsp_if.sv */
// ----------------------------------------------------------------------------
// vgacc_rsp_if
// result channel: one transaction per request
// ----------------------------------------------------------------------------
interface vgacc_rsp_if;
	logic                                    valid;
	logic                                    ready;
	logic [vgacc_pkg::STATUS_W-1:0]          status;
	logic signed [vgacc_pkg::COORD_BITS-1:0] cell_x;
	logic signed [vgacc_pkg::COORD_BITS-1:0] cell_y;
	logic signed [vgacc_pkg::COORD_BITS-1:0] cell_z;
	logic [vgacc_pkg::OUT_SLOT_W-1:0]        slot;
	logic [vgacc_pkg::COUNT_BITS-1:0]        point_count;
	logic [vgacc_pkg::ENERGY_W-1:0]          energy;

	modport source (output valid, status, cell_x, cell_y, cell_z, slot, point_count, energy,
		input ready);
	modport sink (input valid, status, cell_x, cell_y, cell_z, slot, point_count, energy,
		output ready);
endinterface

/* src/vgacc_ram.sv */
// ----------------------------------------------------------------------------
// vgacc_ram
// generic single write port memory with registered read
// ----------------------------------------------------------------------------
module vgacc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* src/vgacc_div.sv */
// ----------------------------------------------------------------------------
// vgacc_div
// shared floored divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module vgacc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  vgacc_pkg::div_req_t div_req,
	output vgacc_pkg::div_rsp_t div_rsp
);

	logic                                 busy_q;
	logic                                 done_q;
	logic [vgacc_pkg::DIV_CNT_W-1:0]      cnt_q;
	logic                                 neg_q;
	logic [vgacc_pkg::DIVIDEND_W-1:0]     acc_q;
	logic [vgacc_pkg::DIVISOR_W-1:0]      rem_q;
	logic [vgacc_pkg::DIVISOR_W-1:0]      den_q;
	logic [vgacc_pkg::QUOT_W-1:0]         quot_q;

	logic [vgacc_pkg::DIVISOR_W:0]        trial;
	logic [vgacc_pkg::DIVISOR_W:0]        diff;
	logic                                 ge;
	logic [vgacc_pkg::DIVISOR_W-1:0]      rem_nx;
	logic [vgacc_pkg::DIVIDEND_W-1:0]     acc_nx;
	logic [vgacc_pkg::QUOT_W-1:0]         mag_nx;
	logic [vgacc_pkg::QUOT_W-1:0]         quot_nx;
	logic [vgacc_pkg::DIVIDEND_W-1:0]     num_mag;

	assign trial   = {rem_q, acc_q[vgacc_pkg::DIVIDEND_W-1]};
	assign diff    = trial - {1'b0, den_q};
	assign ge      = trial >= {1'b0, den_q};
	assign rem_nx  = ge ? diff[vgacc_pkg::DIVISOR_W-1:0] : trial[vgacc_pkg::DIVISOR_W-1:0];
	assign acc_nx  = {acc_q[vgacc_pkg::DIVIDEND_W-2:0], ge};
	assign mag_nx  = {1'b0, acc_nx};
	assign num_mag = div_req.num[vgacc_pkg::DIVIDEND_W-1] ? (~div_req.num + 1'b1) : div_req.num;

	// floor for a negative dividend: -(q+1) when a remainder is left
	always_comb begin
		if (!neg_q) begin
			quot_nx = mag_nx;
		end else if (rem_nx != '0) begin
			quot_nx = ~mag_nx;
		end else begin
			quot_nx = -mag_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (div_req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= vgacc_pkg::DIV_CNT_W'(vgacc_pkg::DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == vgacc_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_req.start) begin
			neg_q <= div_req.num[vgacc_pkg::DIVIDEND_W-1];
			acc_q <= num_mag;
			rem_q <= '0;
			den_q <= div_req.den;
		end else if (busy_q) begin
			acc_q <= acc_nx;
			rem_q <= rem_nx;
			if (cnt_q == vgacc_pkg::DIV_CNT_W'(1)) begin
				quot_q <= quot_nx;
			end
		end
	end

	assign div_rsp = '{done: done_q, quot: quot_q};

endmodule

/* src/vgacc_mul.sv */
// ----------------------------------------------------------------------------
// vgacc_mul
// unsigned multiplier in two partial products, low half of b then high half
// ----------------------------------------------------------------------------
module vgacc_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  vgacc_pkg::mul_req_t mul_req,
	output vgacc_pkg::mul_rsp_t mul_rsp
);

	logic                                              lo_q;
	logic                                              hi_q;
	logic                                              done_q;
	logic [vgacc_pkg::MAG_W-1:0]                       a_q;
	logic [vgacc_pkg::MAG_W-1:0]                       b_q;
	logic [vgacc_pkg::PROD_W-1:0]                      acc_q;
	logic [vgacc_pkg::HALF_W-1:0]                      b_sel;
	logic [vgacc_pkg::MAG_W+vgacc_pkg::HALF_W-1:0]     pp;

	assign b_sel = hi_q ? vgacc_pkg::HALF_W'(b_q >> vgacc_pkg::HALF_W)
	                    : b_q[vgacc_pkg::HALF_W-1:0];
	assign pp    = a_q * b_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q   <= 1'b0;
			hi_q   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			lo_q   <= mul_req.start;
			hi_q   <= lo_q;
			done_q <= hi_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mul_req.start) begin
			a_q <= mul_req.a;
			b_q <= mul_req.b;
		end
		if (lo_q) begin
			acc_q <= vgacc_pkg::PROD_W'(pp);
		end else if (hi_q) begin
			acc_q <= acc_q + (vgacc_pkg::PROD_W'(pp) << vgacc_pkg::HALF_W);
		end
	end

	assign mul_rsp = '{done: done_q, prod: acc_q};

endmodule

/* src/voxel_gaussian_accumulator_core.sv */
// ----------------------------------------------------------------------------
// voxel_gaussian_accumulator_core
// per-voxel running mean and scatter of 3d points in a probed hash table
// ----------------------------------------------------------------------------
// One request is handled at a time; the result register lets the next request
// in while a result waits. After reset, and for every clear request, the table
// is swept one slot per cycle over all 4096 slots, during which no request is
// taken (a clear returns its result at the end of the sweep). An add request
// runs three cell divisions on the shared 1-bit-per-cycle divider, then a key
// read and compare per probe; a new voxel or a drop ends there. An update of an
// existing voxel adds three mean divisions on the same divider and six scatter
// products on the multiplier.
module voxel_gaussian_accumulator_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [vgacc_pkg::VS_W-1:0] cfg_wdata,
	vgacc_req_if.sink                  req,
	vgacc_rsp_if.source                rsp
);

	typedef enum logic [14:0] {
		S_SWEEP = 15'b000000000000001,
		S_IDLE  = 15'b000000000000010,
		S_CDIV  = 15'b000000000000100,
		S_HASH  = 15'b000000000001000,
		S_PRD   = 15'b000000000010000,
		S_PCMP  = 15'b000000000100000,
		S_NEW   = 15'b000000001000000,
		S_MGO   = 15'b000000010000000,
		S_MDIV  = 15'b000000100000000,
		S_XGO   = 15'b000001000000000,
		S_XMUL  = 15'b000010000000000,
		S_ACC   = 15'b000100000000000,
		S_WB    = 15'b001000000000000,
		S_EN    = 15'b010000000000000,
		S_RESP  = 15'b100000000000000
	} state_t;

	localparam int CW = vgacc_pkg::COORD_BITS;
	localparam int SW = vgacc_pkg::SLOT_W;

	state_t                                  state_q;
	logic [vgacc_pkg::VS_W-1:0]              vs_q;
	logic [vgacc_pkg::VS_W-1:0]              vs_eff;
	logic [SW-1:0]                           sweep_q;
	logic                                    sweep_emit_q;
	logic [1:0]                              axis_q;
	logic [2:0]                              k_q;
	logic [vgacc_pkg::PROBE_W-1:0]           probe_q;
	logic [SW-1:0]                           hash_q;
	logic [SW-1:0]                           slot_q;

	logic signed [CW-1:0]                    p_q [3];
	logic signed [CW-1:0]                    c_q [3];
	logic signed [vgacc_pkg::MEAN_W-1:0]     mean_q [3];
	logic signed [vgacc_pkg::DIFF_W-1:0]     d_q [3];
	logic signed [vgacc_pkg::DIFF_W-1:0]     e_q [3];
	logic signed [vgacc_pkg::SCAT_W-1:0]     scat_q [6];
	logic [vgacc_pkg::COUNT_BITS-1:0]        count_q;
	logic                                    neg_q;
	logic signed [vgacc_pkg::SCAT_W-1:0]     incr_q;
	logic [vgacc_pkg::ENERGY_W-1:0]          epart_q;

	vgacc_pkg::status_t                      res_status_q;
	logic [SW-1:0]                           res_slot_q;
	logic [vgacc_pkg::COUNT_BITS-1:0]        res_count_q;
	logic [vgacc_pkg::ENERGY_W-1:0]          res_energy_q;

	logic                                    out_valid_q;
	logic [vgacc_pkg::STATUS_W-1:0]          out_status_q;
	logic signed [CW-1:0]                    out_cx_q, out_cy_q, out_cz_q;
	logic [vgacc_pkg::OUT_SLOT_W-1:0]        out_slot_q;
	logic [vgacc_pkg::COUNT_BITS-1:0]        out_count_q;
	logic [vgacc_pkg::ENERGY_W-1:0]          out_energy_q;

	logic                                    div_start_q;
	logic [vgacc_pkg::DIVIDEND_W-1:0]        div_num_q;
	logic [vgacc_pkg::DIVISOR_W-1:0]         div_den_q;
	logic                                    mul_start_q;
	logic [vgacc_pkg::MAG_W-1:0]             mul_a_q, mul_b_q;
	vgacc_pkg::div_req_t                     div_req;
	vgacc_pkg::div_rsp_t                     div_rsp;
	vgacc_pkg::mul_req_t                     mul_req;
	vgacc_pkg::mul_rsp_t                     mul_rsp;

	logic                                    key_we, row_we, ram_re;
	logic [SW-1:0]                           key_waddr, raddr;
	logic [vgacc_pkg::KEY_W-1:0]             key_wdata, key_rd;
	logic [vgacc_pkg::COUNT_BITS-1:0]        cnt_wdata, cnt_rd;
	logic [3*vgacc_pkg::MEAN_W-1:0]          mean_wdata, mean_rd;
	logic [6*vgacc_pkg::SCAT_W-1:0]          scat_wdata, scat_rd;

	logic                                    acc_in;
	logic                                    load_out;
	logic                                    key_hit;
	logic signed [vgacc_pkg::MEAN_W-1:0]     pq_w;
	logic signed [vgacc_pkg::DIFF_W-1:0]     d_w, e_w;
	logic signed [vgacc_pkg::MEAN_W-1:0]     mean_nx;
	logic [1:0]                              row_i, col_j;
	logic signed [vgacc_pkg::DIFF_W-1:0]     d_sel, e_sel;
	logic [vgacc_pkg::PEXT_W-1:0]            pe;
	logic [vgacc_pkg::SCAT_W-1:0]            q_w, qr_w;
	logic signed [vgacc_pkg::SCAT_W-1:0]     incr_w;
	logic [vgacc_pkg::OUT_SLOT_W+SW-1:0]     slot_wide;

	assign vs_eff   = (vs_q == '0) ? vgacc_pkg::VS_W'(1) : vs_q;
	assign acc_in   = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign load_out = (state_q == S_RESP) && (!out_valid_q || rsp.ready);
	assign key_hit  = key_rd[vgacc_pkg::KEY_W-2:0] == {c_q[2], c_q[1], c_q[0]};

	// mean update terms on the current axis
	assign pq_w    = {p_q[axis_q], 8'b0};
	assign d_w     = {pq_w[vgacc_pkg::MEAN_W-1], pq_w} - {mean_q[axis_q][vgacc_pkg::MEAN_W-1],
	                 mean_q[axis_q]};
	assign mean_nx = mean_q[axis_q] + vgacc_pkg::MEAN_W'(div_rsp.quot);
	assign e_w     = {pq_w[vgacc_pkg::MEAN_W-1], pq_w} - {mean_nx[vgacc_pkg::MEAN_W-1], mean_nx};

	// scatter entries in order xx xy xz yy yz zz
	always_comb begin
		case (k_q)
			3'd0:    begin row_i = 2'd0; col_j = 2'd0; end
			3'd1:    begin row_i = 2'd0; col_j = 2'd1; end
			3'd2:    begin row_i = 2'd0; col_j = 2'd2; end
			3'd3:    begin row_i = 2'd1; col_j = 2'd1; end
			3'd4:    begin row_i = 2'd1; col_j = 2'd2; end
			default: begin row_i = 2'd2; col_j = 2'd2; end
		endcase
	end
	assign d_sel = d_q[row_i];
	assign e_sel = e_q[col_j];

	// floor(p / 256) with sign, saturated
	assign pe     = vgacc_pkg::PEXT_W'(mul_rsp.prod);
	assign q_w    = pe[71:8];
	assign qr_w   = q_w + vgacc_pkg::SCAT_W'(neg_q && (pe[7:0] != 8'd0));
	always_comb begin
		if (pe[vgacc_pkg::PEXT_W-1:64] != '0) begin
			incr_w = neg_q ? vgacc_pkg::SCAT_MIN : vgacc_pkg::SCAT_MAX;
		end else begin
			incr_w = neg_q ? -qr_w : qr_w;
		end
	end

	assign div_req = '{start: div_start_q, num: div_num_q, den: div_den_q};
	assign mul_req = '{start: mul_start_q, a: mul_a_q, b: mul_b_q};

	vgacc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.div_req (div_req),
		.div_rsp (div_rsp)
	);

	vgacc_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.mul_req (mul_req),
		.mul_rsp (mul_rsp)
	);

	// memory ports
	assign ram_re    = (state_q == S_PRD);
	assign raddr     = hash_q + SW'(probe_q);
	assign key_we    = (state_q == S_SWEEP) || (state_q == S_NEW);
	assign key_waddr = (state_q == S_SWEEP) ? sweep_q : slot_q;
	assign key_wdata = (state_q == S_SWEEP) ? '0 : {1'b1, c_q[2], c_q[1], c_q[0]};
	assign row_we    = (state_q == S_NEW) || (state_q == S_WB);

	always_comb begin
		if (state_q == S_NEW) begin
			cnt_wdata  = vgacc_pkg::COUNT_BITS'(1);
			mean_wdata = {p_q[2], 8'b0, p_q[1], 8'b0, p_q[0], 8'b0};
			scat_wdata = '0;
		end else begin
			cnt_wdata  = count_q;
			mean_wdata = {mean_q[2], mean_q[1], mean_q[0]};
			scat_wdata = {scat_q[5], scat_q[4], scat_q[3], scat_q[2], scat_q[1], scat_q[0]};
		end
	end

	vgacc_ram #(.WIDTH(vgacc_pkg::KEY_W), .DEPTH(vgacc_pkg::TABLE_DEPTH)) u_key_ram (
		.clk (clk), .we (key_we), .waddr (key_waddr), .wdata (key_wdata),
		.re (ram_re), .raddr (raddr), .rdata (key_rd)
	);

	vgacc_ram #(.WIDTH(vgacc_pkg::COUNT_BITS), .DEPTH(vgacc_pkg::TABLE_DEPTH)) u_cnt_ram (
		.clk (clk), .we (row_we), .waddr (slot_q), .wdata (cnt_wdata),
		.re (ram_re), .raddr (raddr), .rdata (cnt_rd)
	);

	vgacc_ram #(.WIDTH(3*vgacc_pkg::MEAN_W), .DEPTH(vgacc_pkg::TABLE_DEPTH)) u_mean_ram (
		.clk (clk), .we (row_we), .waddr (slot_q), .wdata (mean_wdata),
		.re (ram_re), .raddr (raddr), .rdata (mean_rd)
	);

	vgacc_ram #(.WIDTH(6*vgacc_pkg::SCAT_W), .DEPTH(vgacc_pkg::TABLE_DEPTH)) u_scat_ram (
		.clk (clk), .we (row_we), .waddr (slot_q), .wdata (scat_wdata),
		.re (ram_re), .raddr (raddr), .rdata (scat_rd)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_SWEEP;
			vs_q         <= vgacc_pkg::VS_RESET;
			sweep_q      <= '0;
			sweep_emit_q <= 1'b0;
			axis_q       <= '0;
			k_q          <= '0;
			probe_q      <= '0;
			div_start_q  <= 1'b0;
			mul_start_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			mul_start_q <= 1'b0;
			if (cfg_we) begin
				vs_q <= cfg_wdata;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_SWEEP: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == '1) begin
						state_q <= sweep_emit_q ? S_RESP : S_IDLE;
					end
				end
				S_IDLE: begin
					if (acc_in) begin
						axis_q <= '0;
						if (!req.req_type) begin
							sweep_q      <= '0;
							sweep_emit_q <= 1'b1;
							state_q      <= S_SWEEP;
						end else begin
							div_start_q <= 1'b1;
							state_q     <= S_CDIV;
						end
					end
				end
				S_CDIV: begin
					if (div_rsp.done) begin
						if (axis_q == 2'd2) begin
							state_q <= S_HASH;
						end else begin
							axis_q      <= axis_q + 1'b1;
							div_start_q <= 1'b1;
						end
					end
				end
				S_HASH: begin
					probe_q <= '0;
					state_q <= S_PRD;
				end
				S_PRD: begin
					state_q <= S_PCMP;
				end
				S_PCMP: begin
					if (!key_rd[vgacc_pkg::KEY_W-1]) begin
						state_q <= S_NEW;
					end else if (key_hit) begin
						if (cnt_rd == vgacc_pkg::CNT_MAX) begin
							state_q <= S_RESP;
						end else begin
							axis_q  <= '0;
							state_q <= S_MGO;
						end
					end else if (probe_q == vgacc_pkg::PROBE_LAST) begin
						state_q <= S_RESP;
					end else begin
						probe_q <= probe_q + 1'b1;
						state_q <= S_PRD;
					end
				end
				S_NEW: begin
					state_q <= S_RESP;
				end
				S_MGO: begin
					div_start_q <= 1'b1;
					state_q     <= S_MDIV;
				end
				S_MDIV: begin
					if (div_rsp.done) begin
						if (axis_q == 2'd2) begin
							k_q     <= '0;
							state_q <= S_XGO;
						end else begin
							axis_q  <= axis_q + 1'b1;
							state_q <= S_MGO;
						end
					end
				end
				S_XGO: begin
					mul_start_q <= 1'b1;
					state_q     <= S_XMUL;
				end
				S_XMUL: begin
					if (mul_rsp.done) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					if (k_q == 3'd5) begin
						state_q <= S_WB;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_XGO;
					end
				end
				S_WB: begin
					state_q <= S_EN;
				end
				S_EN: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (load_out) begin
						sweep_emit_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (acc_in) begin
					p_q[0]       <= req.point_x;
					p_q[1]       <= req.point_y;
					p_q[2]       <= req.point_z;
					c_q[0]       <= '0;
					c_q[1]       <= '0;
					c_q[2]       <= '0;
					res_status_q <= vgacc_pkg::ST_CLEARED;
					res_slot_q   <= '0;
					res_count_q  <= '0;
					res_energy_q <= '0;
					div_num_q    <= {{(vgacc_pkg::DIVIDEND_W-CW){req.point_x[CW-1]}}, req.point_x};
					div_den_q    <= vgacc_pkg::DIVISOR_W'(vs_eff);
				end
			end
			S_CDIV: begin
				if (div_rsp.done) begin
					c_q[axis_q] <= CW'(div_rsp.quot);
					if (axis_q != 2'd2) begin
						div_num_q <= {{(vgacc_pkg::DIVIDEND_W-CW){p_q[axis_q+1'b1][CW-1]}},
						              p_q[axis_q+1'b1]};
					end
				end
			end
			S_HASH: begin
				hash_q <= vgacc_pkg::hash_slot(c_q[0], c_q[1], c_q[2]);
			end
			S_PRD: begin
				slot_q <= raddr;
			end
			S_PCMP: begin
				if (key_rd[vgacc_pkg::KEY_W-1] && key_hit) begin
					count_q   <= cnt_rd + 1'b1;
					mean_q[0] <= mean_rd[0*vgacc_pkg::MEAN_W +: vgacc_pkg::MEAN_W];
					mean_q[1] <= mean_rd[1*vgacc_pkg::MEAN_W +: vgacc_pkg::MEAN_W];
					mean_q[2] <= mean_rd[2*vgacc_pkg::MEAN_W +: vgacc_pkg::MEAN_W];
					for (int i = 0; i < 6; i++) begin
						scat_q[i] <= scat_rd[i*vgacc_pkg::SCAT_W +: vgacc_pkg::SCAT_W];
					end
					if (cnt_rd == vgacc_pkg::CNT_MAX) begin
						res_status_q <= vgacc_pkg::ST_SAT;
					end
				end else if (key_rd[vgacc_pkg::KEY_W-1]) begin
					res_status_q <= vgacc_pkg::ST_FULL;
				end
			end
			S_NEW: begin
				res_status_q <= vgacc_pkg::ST_NEW;
				res_slot_q   <= slot_q;
				res_count_q  <= vgacc_pkg::COUNT_BITS'(1);
			end
			S_MGO: begin
				d_q[axis_q] <= d_w;
				div_num_q   <= d_w;
				div_den_q   <= vgacc_pkg::DIVISOR_W'(count_q);
			end
			S_MDIV: begin
				if (div_rsp.done) begin
					mean_q[axis_q] <= mean_nx;
					e_q[axis_q]    <= e_w;
				end
			end
			S_XGO: begin
				neg_q   <= d_sel[vgacc_pkg::DIFF_W-1] ^ e_sel[vgacc_pkg::DIFF_W-1];
				mul_a_q <= d_sel[vgacc_pkg::DIFF_W-1] ? vgacc_pkg::MAG_W'(-d_sel) : d_sel;
				mul_b_q <= e_sel[vgacc_pkg::DIFF_W-1] ? vgacc_pkg::MAG_W'(-e_sel) : e_sel;
			end
			S_XMUL: begin
				if (mul_rsp.done) begin
					incr_q <= incr_w;
				end
			end
			S_ACC: begin
				scat_q[k_q] <= vgacc_pkg::sat_add(scat_q[k_q], incr_q);
			end
			S_WB: begin
				epart_q <= vgacc_pkg::energy_add(vgacc_pkg::pos_part(scat_q[0]),
				                                 vgacc_pkg::pos_part(scat_q[3]));
			end
			S_EN: begin
				res_status_q <= vgacc_pkg::ST_ADDED;
				res_slot_q   <= slot_q;
				res_count_q  <= count_q;
				res_energy_q <= vgacc_pkg::energy_add(epart_q, vgacc_pkg::pos_part(scat_q[5]));
			end
			default: begin
			end
		endcase
	end

	// result register
	assign slot_wide = {{vgacc_pkg::OUT_SLOT_W{1'b0}}, res_slot_q};

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status_q <= res_status_q;
			out_cx_q     <= c_q[0];
			out_cy_q     <= c_q[1];
			out_cz_q     <= c_q[2];
			out_slot_q   <= slot_wide[vgacc_pkg::OUT_SLOT_W-1:0];
			out_count_q  <= res_count_q;
			out_energy_q <= res_energy_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.cell_x      = out_cx_q;
	assign rsp.cell_y      = out_cy_q;
	assign rsp.cell_z      = out_cz_q;
	assign rsp.slot        = out_slot_q;
	assign rsp.point_count = out_count_q;
	assign rsp.energy      = out_energy_q;

`ifndef SYNTH
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_CDIV || state_q == S_MDIV))
		else $error("divider result outside a division step");

	a_mul_owner: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> (state_q == S_XMUL))
		else $error("multiplier result outside a product step");

	a_clear_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_in && !req.req_type) |=> (state_q == S_SWEEP))
		else $error("clear transaction did not start the sweep");

	a_new_voxel: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == vgacc_pkg::ST_NEW) |->
		(rsp.point_count == vgacc_pkg::COUNT_BITS'(1) && rsp.energy == '0))
		else $error("new voxel with non-initial statistics");
`endif

endmodule

/* verif/tb_voxel_gaussian_accumulator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_voxel_gaussian_accumulator_core
// self-checking bench: points and clears go in, and every result is compared
// with a behavioural model of the voxel table that runs inside the bench
// ----------------------------------------------------------------------------
module tb_voxel_gaussian_accumulator_core;

	localparam int STALL_LIMIT = 20000;
	localparam logic [63:0] S64_MAX = 64'h7fff_ffff_ffff_ffff;

	typedef struct packed {
		vgacc_pkg::status_t                      status;
		logic [vgacc_pkg::COORD_BITS-1:0]        cell_x;
		logic [vgacc_pkg::COORD_BITS-1:0]        cell_y;
		logic [vgacc_pkg::COORD_BITS-1:0]        cell_z;
		logic [vgacc_pkg::OUT_SLOT_W-1:0]        slot;
		logic [vgacc_pkg::COUNT_BITS-1:0]        point_count;
		logic [vgacc_pkg::ENERGY_W-1:0]          energy;
	} voxel_result_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [vgacc_pkg::VS_W-1:0] cfg_wdata;

	vgacc_req_if req ();
	vgacc_rsp_if rsp ();

	voxel_gaussian_accumulator_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp)
	);

	// model of the voxel table
	bit                         occupied [vgacc_pkg::TABLE_DEPTH];
	longint                     cell_key [vgacc_pkg::TABLE_DEPTH][3];
	longint unsigned            pts_in_voxel [vgacc_pkg::TABLE_DEPTH];
	longint                     mean_acc [vgacc_pkg::TABLE_DEPTH][3];
	longint                     scatter_acc [vgacc_pkg::TABLE_DEPTH][6];
	logic [vgacc_pkg::VS_W-1:0] edge_len;

	voxel_result_t pending_results [$];
	int            fail_count;
	int            tx_idle_pct;
	int            rx_idle_pct;
	int            rx_hold_req;
	int            rx_hold_left;
	int            quiet_cycles;
	int            centre_x [12];
	int            centre_y [12];
	int            centre_z [12];

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic longint floor_quot(input longint a, input longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0) begin
			q = q - 1;
		end
		return q;
	endfunction

	// floor(a * b / 256) clamped to the signed 64-bit range
	function automatic longint scaled_product(input longint a, input longint b);
		logic [63:0]  ua, ub, q;
		logic [127:0] pm;
		bit           neg;
		neg = (a < 0) != (b < 0);
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		pm = {64'b0, ua} * {64'b0, ub};
		if (pm[127:64] != 0) begin
			return neg ? longint'(64'h8000_0000_0000_0000) : longint'(S64_MAX);
		end
		q = pm[63:0] >> 8;
		if (neg && pm[7:0] != 0) begin
			q = q + 1;
		end
		if (q > S64_MAX) begin
			return neg ? longint'(64'h8000_0000_0000_0000) : longint'(S64_MAX);
		end
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint clamped_sum(input longint a, input longint b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			return s[64] ? longint'(64'h8000_0000_0000_0000) : longint'(S64_MAX);
		end
		return s[63:0];
	endfunction

	function automatic voxel_result_t apply_request(input logic rtype,
			input logic signed [vgacc_pkg::COORD_BITS-1:0] px,
			input logic signed [vgacc_pkg::COORD_BITS-1:0] py,
			input logic signed [vgacc_pkg::COORD_BITS-1:0] pz);
		voxel_result_t r;
		longint        p [3];
		longint        c [3];
		longint        d [3];
		longint        e [3];
		longint        vs, pq;
		logic [31:0]   h, kx, ky, kz;
		logic [63:0]   en;
		int            s, t, found, k;
		r = '0;
		if (!rtype) begin
			foreach (occupied[n]) begin
				occupied[n] = 1'b0;
			end
			r.status = vgacc_pkg::ST_CLEARED;
			return r;
		end
		vs = (edge_len == 0) ? 1 : longint'(edge_len);
		p[0] = px;
		p[1] = py;
		p[2] = pz;
		for (int a = 0; a < 3; a++) begin
			c[a] = floor_quot(p[a], vs);
		end
		r.cell_x = c[0][vgacc_pkg::COORD_BITS-1:0];
		r.cell_y = c[1][vgacc_pkg::COORD_BITS-1:0];
		r.cell_z = c[2][vgacc_pkg::COORD_BITS-1:0];
		kx = {{(32-vgacc_pkg::COORD_BITS){1'b0}}, r.cell_x};
		ky = {{(32-vgacc_pkg::COORD_BITS){1'b0}}, r.cell_y};
		kz = {{(32-vgacc_pkg::COORD_BITS){1'b0}}, r.cell_z};
		h = (kx * vgacc_pkg::HASH_KX) ^ (ky * vgacc_pkg::HASH_KY) ^ (kz * vgacc_pkg::HASH_KZ);
		found = 0;
		s = 0;
		for (k = 0; k < vgacc_pkg::MAX_PROBES; k++) begin
			t = (h % vgacc_pkg::TABLE_DEPTH + k) % vgacc_pkg::TABLE_DEPTH;
			if (!occupied[t]) begin
				s = t;
				found = 1;
				break;
			end
			if (cell_key[t][0] == c[0] && cell_key[t][1] == c[1] && cell_key[t][2] == c[2]) begin
				s = t;
				found = 2;
				break;
			end
		end
		if (found == 0) begin
			r.status = vgacc_pkg::ST_FULL;
			return r;
		end
		if (found == 1) begin
			occupied[s] = 1'b1;
			pts_in_voxel[s] = 1;
			for (int a = 0; a < 3; a++) begin
				cell_key[s][a] = c[a];
				mean_acc[s][a] = p[a] * 256;
			end
			for (int a = 0; a < 6; a++) begin
				scatter_acc[s][a] = 0;
			end
			r.status = vgacc_pkg::ST_NEW;
			r.slot = vgacc_pkg::OUT_SLOT_W'(s);
			r.point_count = vgacc_pkg::COUNT_BITS'(1);
			return r;
		end
		if (pts_in_voxel[s] >= vgacc_pkg::CNT_MAX) begin
			r.status = vgacc_pkg::ST_SAT;
			return r;
		end
		pts_in_voxel[s] = pts_in_voxel[s] + 1;
		for (int a = 0; a < 3; a++) begin
			pq = p[a] * 256;
			d[a] = pq - mean_acc[s][a];
			mean_acc[s][a] = mean_acc[s][a] + floor_quot(d[a], longint'(pts_in_voxel[s]));
			e[a] = pq - mean_acc[s][a];
		end
		k = 0;
		for (int i = 0; i < 3; i++) begin
			for (int j = i; j < 3; j++) begin
				scatter_acc[s][k] = clamped_sum(scatter_acc[s][k], scaled_product(d[i], e[j]));
				k++;
			end
		end
		en = 0;
		foreach (d[i]) begin
			t = (i == 0) ? 0 : (i == 1) ? 3 : 5;
			if (scatter_acc[s][t] > 0) begin
				en = (64'(scatter_acc[s][t]) > S64_MAX - en) ? S64_MAX : en + scatter_acc[s][t];
			end
		end
		r.status = vgacc_pkg::ST_ADDED;
		r.slot = vgacc_pkg::OUT_SLOT_W'(s);
		r.point_count = pts_in_voxel[s][vgacc_pkg::COUNT_BITS-1:0];
		r.energy = en[vgacc_pkg::ENERGY_W-1:0];
		return r;
	endfunction

	task automatic send_item(input logic rtype, input int px, input int py, input int pz);
		while ($urandom_range(99) < tx_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid    <= 1'b1;
		req.req_type <= rtype;
		req.point_x  <= px[vgacc_pkg::COORD_BITS-1:0];
		req.point_y  <= py[vgacc_pkg::COORD_BITS-1:0];
		req.point_z  <= pz[vgacc_pkg::COORD_BITS-1:0];
		do begin
			@(posedge clk);
		end while (!req.ready);
		pending_results.push_back(apply_request(rtype, px[vgacc_pkg::COORD_BITS-1:0],
			py[vgacc_pkg::COORD_BITS-1:0], pz[vgacc_pkg::COORD_BITS-1:0]));
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic set_voxel_size(input logic [vgacc_pkg::VS_W-1:0] v);
		drain();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		edge_len = v;
	endtask

	task automatic test_field_extremes();
		send_item(1'b1, 0, 0, 0);
		send_item(1'b1, 8388607, 8388607, 8388607);
		send_item(1'b1, -8388608, -8388608, -8388608);
		send_item(1'b1, -1, 511, -513);
		send_item(1'b1, 8388607, -8388608, 1);
		send_item(1'b1, 8388000, -8388000, 5);
		send_item(1'b1, 8388607, -8388608, 1);
		send_item(1'b0, 8388607, 8388607, 8388607);
		send_item(1'b1, 0, 0, 0);
	endtask

	task automatic test_voxel_sizes();
		set_voxel_size(vgacc_pkg::VS_W'(0));
		send_item(1'b1, -3, 7, 0);
		send_item(1'b1, -3, 7, 0);
		set_voxel_size('1);
		send_item(1'b1, -8388608, 8388607, -1);
		send_item(1'b1, 8388607, -8388607, 0);
		send_item(1'b1, 100, -100, 8388606);
		set_voxel_size(vgacc_pkg::VS_W'(1));
		send_item(1'b1, 12, -40, 9);
	endtask

	// same hash for every multiple of the table depth along x with unit voxels
	task automatic test_table_full();
		send_item(1'b0, 0, 0, 0);
		for (int k = 0; k <= vgacc_pkg::MAX_PROBES; k++) begin
			send_item(1'b1, k * vgacc_pkg::TABLE_DEPTH, 0, 0);
		end
		send_item(1'b1, 3 * vgacc_pkg::TABLE_DEPTH, 0, 0);
		send_item(1'b1, vgacc_pkg::MAX_PROBES * vgacc_pkg::TABLE_DEPTH, 0, 0);
	endtask

	task automatic test_random(input int n, input int tx_pct, input int rx_pct,
			input logic [vgacc_pkg::VS_W-1:0] vs);
		int pick, px, py, pz, j;
		set_voxel_size(vs);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		foreach (centre_x[i]) begin
			centre_x[i] = $urandom_range(8000000) - 4000000;
			centre_y[i] = $urandom_range(8000000) - 4000000;
			centre_z[i] = $urandom_range(8000000) - 4000000;
		end
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			j = $urandom_range(11);
			if (pick < 1) begin
				send_item(1'b0, $urandom, $urandom, $urandom);
			end else if (pick < 72) begin
				px = centre_x[j] + $urandom_range(2 * vs) - vs;
				py = centre_y[j] + $urandom_range(2 * vs) - vs;
				pz = centre_z[j] + $urandom_range(2 * vs) - vs;
				send_item(1'b1, px, py, pz);
			end else begin
				send_item(1'b1, $urandom, $urandom, $urandom);
			end
		end
	endtask

	task automatic test_back_pressure();
		tx_idle_pct = 0;
		rx_hold_req = 3000;
		for (int i = 0; i < 12; i++) begin
			send_item(1'b1, centre_x[0] + i, centre_y[0] - i, centre_z[0]);
		end
	endtask

	always @(posedge clk) begin
		if (rx_hold_req > 0) begin
			rx_hold_left = rx_hold_req;
			rx_hold_req = 0;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left = rx_hold_left - 1;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	task automatic compare(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		voxel_result_t w;
		if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				$error("result transaction with nothing outstanding");
				fail_count++;
			end else begin
				w = pending_results.pop_front();
				compare("status", w.status, rsp.status);
				compare("cell_x", w.cell_x, $unsigned(rsp.cell_x));
				compare("cell_y", w.cell_y, $unsigned(rsp.cell_y));
				compare("cell_z", w.cell_z, $unsigned(rsp.cell_z));
				compare("slot", w.slot, rsp.slot);
				compare("point_count", w.point_count, rsp.point_count);
				compare("energy", w.energy, rsp.energy);
			end
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		req.valid    = 1'b0;
		req.req_type = 1'b0;
		req.point_x  = '0;
		req.point_y  = '0;
		req.point_z  = '0;
		rsp.ready    = 1'b0;
		edge_len     = vgacc_pkg::VS_RESET;
		fail_count   = 0;
		tx_idle_pct  = 0;
		rx_idle_pct  = 0;
		rx_hold_req  = 0;
		rx_hold_left = 0;
		quiet_cycles = 0;
		foreach (occupied[n]) begin
			occupied[n] = 1'b0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_field_extremes();
		test_voxel_sizes();
		test_table_full();
		test_random(230, 16, 64, vgacc_pkg::VS_W'(300));
		test_random(230, 64, 16, vgacc_pkg::VS_W'(37));
		test_back_pressure();
		test_random(230, 0, 0, vgacc_pkg::VS_W'(4096));
		drain();
		repeat (400) @(posedge clk);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule

/* voxel_gaussian_accumulator_core.f */
src/vgacc_pkg.sv
src/vgacc_req_if.sv
src/vgacc_rsp_if.sv
src/vgacc_ram.sv
src/vgacc_div.sv
src/vgacc_mul.sv
src/voxel_gaussian_accumulator_core.sv
verif/tb_voxel_gaussian_accumulator_core.sv
